// ----- hw/rtl/rrip_pkg.sv -----
// Shared constants and types for the RRIP region-hint replacement block.
package rrip_pkg;

  localparam int WAYS      = 16;    // power of two, 2..16 (way output is 4 bits)
  localparam int SETS      = 2048;  // power of two
  localparam int RRPV_BITS = 3;

  localparam int SET_IN_W  = 11;
  localparam int TAG_W     = 40;
  localparam int HINT_W    = 2;
  localparam int WAY_OUT_W = 4;

  localparam int WAY_W     = $clog2(WAYS);
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_ADR_W = SET_W + WAY_W;

  localparam logic [RRPV_BITS-1:0] RRPV_MAX  = {RRPV_BITS{1'b1}};
  localparam logic [RRPV_BITS-1:0] RRPV_MID  = RRPV_MAX - RRPV_BITS'(1);
  localparam logic [RRPV_BITS-1:0] RRPV_NEAR = RRPV_BITS'(1);
  localparam logic [RRPV_BITS-1:0] RRPV_ZERO = '0;

  localparam logic [HINT_W-1:0] HINT_NONE     = 2'd0;
  localparam logic [HINT_W-1:0] HINT_MODERATE = 2'd1;
  localparam logic [HINT_W-1:0] HINT_HIGH     = 2'd2;

  typedef logic [WAY_W-1:0]     way_t;
  typedef logic [RRPV_BITS-1:0] rrpv_t;
  typedef logic [TAG_W-1:0]     tag_t;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][RRPV_BITS-1:0] rrpv;
  } meta_t;

  typedef struct packed {
    logic en;     // a way is presented this cycle
    logic first;  // way 0: restart the scan
  } scan_ctl_t;

  typedef struct packed {
    logic  found;
    way_t  hit_way;
    rrpv_t best;
    way_t  victim;
  } scan_res_t;

endpackage

// ----- hw/rtl/rrip_region_hint_replacement.sv -----
// Top level: RRIP tag store with reuse-hint insertion and per-way scan.
//
//  channel   | signals                                | handshake
//  ----------+----------------------------------------+------------------------------
//  request   | set_index, block_addr, reuse_hint      | word taken when start && !busy
//  result    | hit, way                               | word valid while done is high
//
//  An access reads the set's metadata row, then the single tag comparator and max unit
//  walk the ways (one tag memory read each), then the row is written back, and the result
//  strobe comes on the cycle after write-back, where the next start is already taken.
//  After reset a clearing pass walks the metadata memory one set per cycle over all
//  SETS sets (2048 here) with busy high; every way becomes invalid with the top RRPV.
//  The receiver cannot stall: done lasts exactly one cycle.
module rrip_region_hint_replacement (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rrip_pkg::SET_IN_W-1:0] set_index,
  input  logic [rrip_pkg::TAG_W-1:0]    block_addr,
  input  logic [rrip_pkg::HINT_W-1:0]   reuse_hint,
  output logic                          busy,
  output logic                          done,
  output logic                          hit,
  output logic [rrip_pkg::WAY_OUT_W-1:0] way
);
  import rrip_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  localparam way_t LAST_WAY = way_t'(WAYS - 1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  // Storage: metadata row per set, tags per set and way.
  meta_t meta_mem [SETS];
  tag_t  tag_mem  [SETS * WAYS];

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [SET_W-1:0] clr_cnt;
  logic [SET_W-1:0] set_q;
  tag_t             key_q;
  logic [HINT_W-1:0] hint_q;
  way_t             scan_way;

  meta_t meta_q;
  tag_t  tag_q;
  meta_t meta_new;
  meta_t meta_clear;
  logic  accept;

  logic           [TAG_ADR_W-1:0] tag_rd_adr;
  way_t           tag_rd_way;
  scan_ctl_t      scan_ctl;
  scan_res_t      scan_res;
  rrpv_t          diff;
  rrpv_t          fill;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == LAST_SET) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_SCAN;
      ST_SCAN:   if (scan_way == LAST_WAY) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      scan_way <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      // advance the way pointer only while scanning
      if (state == ST_SCAN) begin
        scan_way <= scan_way + way_t'(1);
      end else begin
        scan_way <= '0;
      end
    end
  end

  // Latch the request word; the set index wraps to the low bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q  <= set_index[SET_W-1:0];
      key_q  <= block_addr;
      hint_q <= reuse_hint;
    end
  end

  // Tag reads run one way ahead of the comparator.
  assign tag_rd_way = (state == ST_SCAN) ? scan_way + way_t'(1) : '0;
  assign tag_rd_adr = {set_q, tag_rd_way};

  always_comb begin
    meta_clear.valid = '0;
    for (int w = 0; w < WAYS; w++) begin
      meta_clear.rrpv[w] = RRPV_MAX;
    end
  end

  // Metadata memory: clear sweep, row read in LOAD, write-back in UPDATE.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      meta_mem[clr_cnt] <= meta_clear;
    end else if (state == ST_UPDATE) begin
      meta_mem[set_q] <= meta_new;
    end
    if (state == ST_LOAD) begin
      meta_q <= meta_mem[set_q];
    end
  end

  // Tag memory: one read per cycle while loading or scanning, fill on a miss.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && !scan_res.found) begin
      tag_mem[{set_q, scan_res.victim}] <= key_q;
    end
    if (state == ST_LOAD || state == ST_SCAN) begin
      tag_q <= tag_mem[tag_rd_adr];
    end
  end

  assign scan_ctl.en    = (state == ST_SCAN);
  assign scan_ctl.first = (scan_way == '0);

  rrip_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .cur_way   (scan_way),
    .cur_valid (meta_q.valid[scan_way]),
    .cur_tag   (tag_q),
    .cur_rrpv  (meta_q.rrpv[scan_way]),
    .key       (key_q),
    .res       (scan_res)
  );

  // Insertion value by hint; the unused code counts as no hint.
  always_comb begin
    case (hint_q)
      HINT_HIGH:     fill = RRPV_NEAR;
      HINT_MODERATE: fill = RRPV_MID;
      default:       fill = RRPV_MAX;
    endcase
  end

  assign diff = RRPV_MAX - scan_res.best;

  // New metadata row: promote on a hit; age the set and insert on a miss.
  always_comb begin
    meta_new = meta_q;
    if (scan_res.found) begin
      if (hint_q == HINT_HIGH) begin
        meta_new.rrpv[scan_res.hit_way] = RRPV_ZERO;
      end else if (meta_q.rrpv[scan_res.hit_way] != RRPV_ZERO) begin
        meta_new.rrpv[scan_res.hit_way] = meta_q.rrpv[scan_res.hit_way] - rrpv_t'(1);
      end
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        meta_new.rrpv[w] = meta_q.rrpv[w] + diff;
      end
      meta_new.rrpv[scan_res.victim]  = fill;
      meta_new.valid[scan_res.victim] = 1'b1;
    end
  end

  // Result word, shown for one cycle after write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit <= scan_res.found;
      way <= scan_res.found ? WAY_OUT_W'(scan_res.hit_way) : WAY_OUT_W'(scan_res.victim);
    end
  end

  // Checks.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without write-back");

  a_scan_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_way == LAST_WAY) |=> state == ST_UPDATE)
    else $error("scan did not end after the last way");

endmodule

// ----- hw/rtl/rrip_scan.sv -----
// Shared tag comparator and running maximum, stepped one way per cycle.
module rrip_scan (
  input  logic              clk,
  input  logic              rst,
  input  rrip_pkg::scan_ctl_t ctl,
  input  rrip_pkg::way_t    cur_way,
  input  logic              cur_valid,
  input  rrip_pkg::tag_t    cur_tag,
  input  rrip_pkg::rrpv_t   cur_rrpv,
  input  rrip_pkg::tag_t    key,
  output rrip_pkg::scan_res_t res
);
  import rrip_pkg::*;

  logic match;

  assign match = cur_valid && (cur_tag == key);

  // Lowest matching way wins; first way holding the largest value wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
    end else if (ctl.en) begin
      if (ctl.first) begin
        res.found <= match;
      end else if (match) begin
        res.found <= 1'b1;
      end
    end
    if (ctl.en) begin
      if (ctl.first) begin
        res.hit_way <= cur_way;
        res.best    <= cur_rrpv;
        res.victim  <= cur_way;
      end else begin
        if (match && !res.found) begin
          res.hit_way <= cur_way;
        end
        if (cur_rrpv > res.best) begin
          res.best   <= cur_rrpv;
          res.victim <= cur_way;
        end
      end
    end
  end

endmodule
